// ===== rtl/ntms_pkg.sv =====
// Shared types and constants of the neighbor table.
package ntms_pkg;

  localparam int CAPACITY    = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ID_W        = 16;
  localparam int MEAS_W      = 16;
  localparam int REC_W       = 3 * MEAS_W;
  localparam int COUNT_W     = 5;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_MISS,
    ST_COUNT,
    ST_SWEEP,
    ST_EMPTY
  } state_t;

  typedef enum logic [1:0] {
    LD_HIT,
    LD_NEW,
    LD_HEAD
  } load_sel_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_CLEAR
  } fill_op_t;

  typedef struct packed {
    logic             capture;
    logic             rotate;
    logic             append;
    load_sel_t        load_sel;
    fill_op_t         fill_op;
    logic             clear_marks;
    logic             emit;
    logic             found;
    logic             show_meas;
    logic             removed;
    logic             use_keep;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] keep;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             hit;
    logic             idx_mark;
    logic             head_mark;
    logic             out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ntms_dpath.sv =====
// Datapath: age-ordered slot rows, request latch, fill level and output register.
module ntms_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  ntms_pkg::dp_cmd_t                   cmd,
  output ntms_pkg::dp_stat_t                  stat,
  input  logic [ntms_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [ntms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic [ntms_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int CAP   = ntms_pkg::CAPACITY;
  localparam int IDX_W = ntms_pkg::IDX_W;
  localparam int CNT_W = ntms_pkg::CNT_W;
  localparam int ID_W  = ntms_pkg::ID_W;
  localparam int M_W   = ntms_pkg::MEAS_W;
  localparam int REC_W = ntms_pkg::REC_W;
  localparam int C_W   = ntms_pkg::COUNT_W;

  // latched request
  logic [ID_W-1:0]  key_id;
  logic [REC_W-1:0] key_meas;
  logic             key_win;

  logic [ID_W-1:0]  slot_id   [CAP];
  logic [REC_W-1:0] slot_meas [CAP];
  logic             slot_mark [CAP];
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] fill_dec;
  logic [IDX_W-1:0] top;

  logic [ID_W-1:0]  load_id;
  logic [REC_W-1:0] load_meas;
  logic             load_mark;

  logic             out_valid;
  logic             out_found;
  logic [REC_W-1:0] out_meas;
  logic             out_rvalid;
  logic [ID_W-1:0]  out_rid;
  logic [C_W-1:0]   out_count;
  logic             out_last;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_id   <= in_tdata[ID_W-1:0];
      // distance in the high third, elevation in the low third
      key_meas <= {in_tdata[2*M_W-1:M_W], in_tdata[3*M_W-1:2*M_W],
                   in_tdata[4*M_W-1:3*M_W]};
      key_win  <= in_tdata[4*M_W];
    end
  end

  assign fill_dec = fill - CNT_W'(1);
  assign top      = cmd.append ? fill[IDX_W-1:0] : fill_dec[IDX_W-1:0];

  always_comb begin
    unique case (cmd.load_sel)
      ntms_pkg::LD_HIT: begin
        load_id   = key_id;
        load_meas = key_meas;
        load_mark = slot_mark[cmd.idx] | key_win;
      end
      ntms_pkg::LD_HEAD: begin
        load_id   = slot_id[0];
        load_meas = slot_meas[0];
        load_mark = 1'b0;
      end
      default: begin
        load_id   = key_id;
        load_meas = key_meas;
        load_mark = key_win;
      end
    endcase
  end

  // Rotate: unless appending, rows idx..top-1 take their newer neighbor; row top takes the load.
  for (genvar i = 0; i < CAP; i++) begin : g_row
    logic shift_en;
    logic load_en;
    assign load_en = cmd.rotate && (IDX_W'(i) == top);
    if (i < CAP - 1) begin : g_shift
      assign shift_en = cmd.rotate && !cmd.append && (IDX_W'(i) >= cmd.idx) &&
                        (IDX_W'(i) < top);
      always_ff @(posedge clk) begin
        if (load_en) begin
          slot_id[i]   <= load_id;
          slot_meas[i] <= load_meas;
        end else if (shift_en) begin
          slot_id[i]   <= slot_id[i+1];
          slot_meas[i] <= slot_meas[i+1];
        end
      end
      always_ff @(posedge clk) begin
        if (rst || cmd.clear_marks) begin
          slot_mark[i] <= 1'b0;
        end else if (load_en) begin
          slot_mark[i] <= load_mark;
        end else if (shift_en) begin
          slot_mark[i] <= slot_mark[i+1];
        end
      end
    end else begin : g_newest
      assign shift_en = 1'b0;
      always_ff @(posedge clk) begin
        if (load_en) begin
          slot_id[i]   <= load_id;
          slot_meas[i] <= load_meas;
        end
      end
      always_ff @(posedge clk) begin
        if (rst || cmd.clear_marks) begin
          slot_mark[i] <= 1'b0;
        end else if (load_en) begin
          slot_mark[i] <= load_mark;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.fill_op)
      ntms_pkg::FILL_INC:   fill_next = fill + CNT_W'(1);
      ntms_pkg::FILL_DEC:   fill_next = fill_dec;
      ntms_pkg::FILL_CLEAR: fill_next = '0;
      default:              fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found  <= cmd.found;
      out_meas   <= cmd.show_meas ? slot_meas[cmd.idx] : '0;
      out_rvalid <= cmd.removed;
      out_rid    <= cmd.removed ? slot_id[0] : '0;
      out_count  <= cmd.use_keep ? C_W'(cmd.keep) : C_W'(fill_next);
      out_last   <= cmd.last;
    end
  end

  assign stat = '{fill:      fill,
                  hit:       (slot_id[cmd.idx] == key_id),
                  idx_mark:  slot_mark[cmd.idx],
                  head_mark: slot_mark[0],
                  out_free:  (!out_valid || m_axis_tready)};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(ntms_pkg::OUT_TDATA_W - 4*M_W - C_W){1'b0}}, out_count, out_rid,
                          out_meas[M_W-1:0], out_meas[2*M_W-1:M_W],
                          out_meas[3*M_W-1:2*M_W]};
  assign m_axis_tuser  = {out_rvalid, out_found};
  assign m_axis_tlast  = out_last;

endmodule

// ===== rtl/ntms_ctrl.sv =====
// Controller: sequences search, update, sweep and clear requests over the datapath.
module ntms_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ntms_pkg::OP_W-1:0]   op_in,
  input  ntms_pkg::dp_stat_t          stat,
  output ntms_pkg::dp_cmd_t           cmd
);

  localparam int IDX_W = ntms_pkg::IDX_W;
  localparam int CNT_W = ntms_pkg::CNT_W;

  ntms_pkg::state_t state, state_next;
  ntms_pkg::op_t    op, op_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] steps, steps_next;
  logic [CNT_W-1:0] gone, gone_next;
  logic [CNT_W-1:0] keep, keep_next;
  logic             none, none_next;
  logic [CNT_W-1:0] fill_dec;

  assign s_axis_tready = (state == ntms_pkg::ST_IDLE);
  assign fill_dec      = stat.fill - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    idx   <= idx_next;
    steps <= steps_next;
    gone  <= gone_next;
    keep  <= keep_next;
    none  <= none_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ntms_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (ntms_pkg::op_t'(op_in))
            ntms_pkg::OP_SWEEP: state_next = ntms_pkg::ST_COUNT;
            ntms_pkg::OP_CLEAR: state_next = ntms_pkg::ST_EMPTY;
            default: begin
              state_next = (stat.fill == '0) ? ntms_pkg::ST_MISS : ntms_pkg::ST_SEARCH;
            end
          endcase
        end
      end
      ntms_pkg::ST_SEARCH: begin
        priority if (stat.hit) begin
          state_next = ntms_pkg::ST_HIT;
        end else if (idx == '0) begin
          state_next = ntms_pkg::ST_MISS;
        end
      end
      ntms_pkg::ST_HIT, ntms_pkg::ST_MISS, ntms_pkg::ST_EMPTY: begin
        if (stat.out_free) begin
          state_next = ntms_pkg::ST_IDLE;
        end
      end
      ntms_pkg::ST_COUNT: begin
        if (steps == '0) begin
          state_next = ntms_pkg::ST_SWEEP;
        end
      end
      ntms_pkg::ST_SWEEP: begin
        if (steps == '0) begin
          state_next = none ? ntms_pkg::ST_EMPTY : ntms_pkg::ST_IDLE;
        end
      end
      default: state_next = ntms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_sel = ntms_pkg::LD_NEW;
    cmd.fill_op  = ntms_pkg::FILL_HOLD;
    cmd.idx      = idx;
    cmd.keep     = keep;
    op_next      = op;
    idx_next     = idx;
    steps_next   = steps;
    gone_next    = gone;
    keep_next    = keep;
    none_next    = none;
    unique case (state)
      ntms_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          op_next     = ntms_pkg::op_t'(op_in);
          idx_next    = (ntms_pkg::op_t'(op_in) == ntms_pkg::OP_SWEEP) ? '0 :
                        fill_dec[IDX_W-1:0];
          steps_next  = stat.fill;
          keep_next   = '0;
        end
      end
      ntms_pkg::ST_SEARCH: begin
        if (!stat.hit && idx != '0) begin
          idx_next = idx - IDX_W'(1);
        end
      end
      ntms_pkg::ST_HIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.found = 1'b1;
          cmd.last  = 1'b1;
          if (op == ntms_pkg::OP_ADD) begin
            cmd.rotate   = 1'b1;
            cmd.load_sel = ntms_pkg::LD_HIT;
          end else begin
            cmd.show_meas = 1'b1;
          end
        end
      end
      ntms_pkg::ST_MISS: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (op == ntms_pkg::OP_ADD) begin
            cmd.rotate = 1'b1;
            // full table: the search ended at the oldest row, which drops out
            if (stat.fill == CNT_W'(ntms_pkg::CAPACITY)) begin
              cmd.removed = 1'b1;
            end else begin
              cmd.append  = 1'b1;
              cmd.fill_op = ntms_pkg::FILL_INC;
            end
          end
        end
      end
      ntms_pkg::ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (op == ntms_pkg::OP_CLEAR) begin
            cmd.fill_op     = ntms_pkg::FILL_CLEAR;
            cmd.clear_marks = 1'b1;
          end
        end
      end
      ntms_pkg::ST_COUNT: begin
        // first pass counts survivors so every removal result carries the final count
        if (steps != '0) begin
          keep_next  = keep + CNT_W'(stat.idx_mark);
          idx_next   = idx + IDX_W'(1);
          steps_next = steps - CNT_W'(1);
        end else begin
          idx_next   = '0;
          steps_next = stat.fill;
          gone_next  = stat.fill - keep;
          none_next  = (stat.fill == keep);
        end
      end
      ntms_pkg::ST_SWEEP: begin
        // oldest row leaves; marked rows go back on the newest end with mark cleared
        if (steps != '0) begin
          if (stat.head_mark) begin
            cmd.rotate   = 1'b1;
            cmd.load_sel = ntms_pkg::LD_HEAD;
            steps_next   = steps - CNT_W'(1);
          end else if (stat.out_free) begin
            cmd.rotate   = 1'b1;
            cmd.load_sel = ntms_pkg::LD_HEAD;
            cmd.fill_op  = ntms_pkg::FILL_DEC;
            cmd.emit     = 1'b1;
            cmd.removed  = 1'b1;
            cmd.use_keep = 1'b1;
            cmd.last     = (gone == CNT_W'(1));
            gone_next    = gone - CNT_W'(1);
            steps_next   = steps - CNT_W'(1);
          end
        end
      end
      default: begin
        cmd.idx = idx;
      end
    endcase
  end

endmodule

// ===== rtl/neighbor_table_mark_sweep.sv =====
// Top level of the neighbor table with mark-and-sweep aging.

// Keeps up to 16 neighbors, oldest first, and serves one request at a time:
// s_axis_tready is high only while no request is in progress. An add or a
// lookup compares one stored id per cycle from the newest end. A sweep walks
// the table twice, once to count the marked rows and once to rotate every
// row out of the oldest slot, and emits one result per removed id, or a
// single result when nothing is removed. A stalled master side holds
// results back and stretches the request by the stall; the output
// register lets the last result wait while the next request is taken.
module neighbor_table_mark_sweep (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // robot_id, distance, azimuth, elevation, mark_window, zero pad
  input  logic [ntms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [ntms_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // found_distance, found_azimuth, found_elevation, removed_id, neighbor_count, zero pad
  output logic [ntms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // found, removed_valid
  output logic [ntms_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast
);

  ntms_pkg::dp_cmd_t  cmd;
  ntms_pkg::dp_stat_t stat;

  ntms_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op_in         (s_axis_tuser),
    .stat          (stat),
    .cmd           (cmd)
  );

  ntms_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_tdata      (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= ntms_pkg::CNT_W'(ntms_pkg::CAPACITY))
    else $error("fill level beyond capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending result");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[68:64] <= ntms_pkg::COUNT_W'(ntms_pkg::CAPACITY)))
    else $error("reported count beyond capacity");

endmodule
